/* design/dsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants for the dense shortest path block
// Beat formats, command codes, sizes and the saturating distance helpers.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int NODES       = 8;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 24;

  localparam int NODE_BITS = $clog2(NODES);
  localparam int CNT_BITS  = $clog2(NODES + 1);
  localparam int ADDR_BITS = $clog2(NODES * NODES);
  localparam int SUM_BITS  = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  localparam logic [WEIGHT_BITS-1:0] NO_EDGE  = {WEIGHT_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0]   DIST_INF = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0]   DIST_MAX = DIST_INF - DIST_BITS'(1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_RUN   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] weight;
    logic [2:0]  source;
  } req_t;

  typedef struct packed {
    logic [2:0]  node;
    logic [23:0] distance;
    logic        reachable;
    logic        last;
  } rsp_t;

  // Operands for the shared add/compare unit
  typedef struct packed {
    logic                 add_en;
    logic [DIST_BITS-1:0] base;
    logic [DIST_BITS-1:0] addend;
    logic [DIST_BITS-1:0] bound;
  } alu_req_t;

  function automatic logic [DIST_BITS-1:0] sat_dist(input logic [SUM_BITS-1:0] v);
    logic [DIST_BITS-1:0] r;
    if (v > SUM_BITS'(DIST_MAX)) r = DIST_MAX;
    else                         r = v[DIST_BITS-1:0];
    return r;
  endfunction

  function automatic logic [DIST_BITS-1:0] edge_dist(input logic [WEIGHT_BITS-1:0] w);
    logic [DIST_BITS-1:0] r;
    if (w == NO_EDGE) r = DIST_INF;
    else              r = sat_dist(SUM_BITS'(w));
    return r;
  endfunction

endpackage

/* design/dsp_weight_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_weight_mem: edge weight matrix
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dsp_weight_mem
  import dsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_BITS-1:0]   waddr,
  input  logic [WEIGHT_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0]   raddr,
  output logic [WEIGHT_BITS-1:0] rdata
);

  logic [WEIGHT_BITS-1:0] mem [NODES*NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/dsp_path_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_path_alu: shared saturating add and less-than compare
// Used for the minimum search (no add) and for edge relaxation (add).
// ----------------------------------------------------------------------------
module dsp_path_alu
  import dsp_pkg::*;
(
  input  alu_req_t             req,
  output logic [DIST_BITS-1:0] value,
  output logic                 less
);

  logic [SUM_BITS-1:0] sum;

  always_comb begin
    sum   = SUM_BITS'(req.base) + SUM_BITS'(req.addend);
    value = req.add_en ? sat_dist(sum) : req.base;
    less  = (value < req.bound);
  end

endmodule

/* design/dense_shortest_path.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_shortest_path: single-source shortest paths over a dense matrix
// Shortest-first search with a linear minimum scan, one node per cycle.
// ----------------------------------------------------------------------------
// A write beat (cmd = CMD_WRITE) stores one edge weight; the
// all-ones weight means no edge, and a row or col beyond the node count is
// dropped. A run beat (cmd = CMD_RUN) names a source node; the block then
// drops req_ready until all NODES result beats have been loaded into the
// output register, in node order, with last set on the final node. A run
// first loads the source row, then for each settled node does a minimum
// search over all nodes plus a relaxation sweep over the picked node's row,
// then a closing search, and then sends the NODES beats out. Its length is
// set by the single read port of the weight memory and the one shared
// add/compare unit, each visiting one node per cycle.
// Results stall only when rsp_ready is held low. Weights never written are
// undefined; distances are 2^DIST_BITS-1 when unreachable and saturate at
// one below that.
// ----------------------------------------------------------------------------
module dense_shortest_path
  import dsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_FIND  = 5'b00100,
    S_RELAX = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                 state;
  logic [CNT_BITS-1:0]    cnt;      // sweep position; read side leads by one
  logic [NODE_BITS-1:0]   src;
  logic [NODE_BITS-1:0]   pick;
  logic [DIST_BITS-1:0]   least;
  logic                   found;
  logic [NODES-1:0]       settled;
  logic [DIST_BITS-1:0]   best_dist [NODES];

  // Memory hookup
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  logic [ADDR_BITS-1:0]   mem_raddr;
  logic [WEIGHT_BITS-1:0] mem_rdata;
  logic [NODE_BITS-1:0]   row_base;

  // Shared unit
  alu_req_t               alu_req;
  logic [DIST_BITS-1:0]   alu_value;
  logic                   alu_less;

  logic                   accept;
  logic                   in_range;
  logic                   src_ok;
  logic [NODE_BITS-1:0]   idx;      // node under the search / emit
  logic [NODE_BITS-1:0]   jd;       // node whose weight just came back
  logic [DIST_BITS-1:0]   edge_w;
  logic                   take;
  logic                   sweep_end;
  logic                   emit_go;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign in_range  = ({1'b0, req.row} < 4'(NODES)) && ({1'b0, req.col} < 4'(NODES));
  assign src_ok    = ({1'b0, req.source} < 4'(NODES));

  assign idx       = cnt[NODE_BITS-1:0];
  assign jd        = NODE_BITS'(cnt - CNT_BITS'(1));
  assign sweep_end = (cnt == CNT_BITS'(NODES));
  assign edge_w    = edge_dist(mem_rdata);

  // Weight matrix: writes from the request, reads of the row being swept
  assign mem_we    = accept && (req.cmd == CMD_WRITE) && in_range;
  assign mem_waddr = ADDR_BITS'(req.row) * ADDR_BITS'(NODES) + ADDR_BITS'(req.col);
  assign row_base  = (state == S_INIT) ? src : pick;
  assign mem_raddr = ADDR_BITS'(row_base) * ADDR_BITS'(NODES) + ADDR_BITS'(idx);

  dsp_weight_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (req.weight),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Search compares best_dist[idx] against the running minimum; relaxation
  // compares least + edge against the current distance of the neighbor.
  always_comb begin
    if (state == S_RELAX) begin
      alu_req.add_en = 1'b1;
      alu_req.base   = least;
      alu_req.addend = edge_w;
      alu_req.bound  = best_dist[jd];
    end else begin
      alu_req.add_en = 1'b0;
      alu_req.base   = best_dist[idx];
      alu_req.addend = '0;
      alu_req.bound  = least;
    end
  end

  dsp_path_alu u_alu (
    .req   (alu_req),
    .value (alu_value),
    .less  (alu_less)
  );

  assign take    = !settled[idx] && alu_less;
  assign emit_go = (state == S_EMIT) && (!rsp_valid || rsp_ready);

  // Sequencer and settled marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      settled <= '0;
      found   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (req.cmd == CMD_RUN) && src_ok) begin
            state   <= S_INIT;
            cnt     <= '0;
            settled <= NODES'(1) << req.source;
          end
        end
        S_INIT: begin
          if (sweep_end) begin
            state <= S_FIND;
            cnt   <= '0;
            found <= 1'b0;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        S_FIND: begin
          if (take) begin
            found <= 1'b1;
          end
          if (cnt == CNT_BITS'(NODES - 1)) begin
            cnt <= '0;
            if (found || take) begin
              state                              <= S_RELAX;
              settled[take ? idx : pick]         <= 1'b1;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        S_RELAX: begin
          if (sweep_end) begin
            state <= S_FIND;
            cnt   <= '0;
            found <= 1'b0;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            cnt <= cnt + CNT_BITS'(1);
            if (cnt == CNT_BITS'(NODES - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: source, running minimum, picked node, distances
  always_ff @(posedge clk) begin
    if (accept && (req.cmd == CMD_RUN)) begin
      src <= req.source;
    end
    if ((state == S_INIT || state == S_RELAX) && sweep_end) begin
      least <= DIST_INF;
    end
    if (state == S_FIND && take) begin
      least <= alu_value;
      pick  <= idx;
    end
    if (state == S_INIT && cnt != '0) begin
      best_dist[jd] <= (jd == src) ? '0 : edge_w;
    end
    if (state == S_RELAX && cnt != '0 && !settled[jd] && edge_w != DIST_INF && alu_less) begin
      best_dist[jd] <= alu_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      rsp.node      <= 3'(idx);
      rsp.distance  <= 24'(best_dist[idx]);
      rsp.reachable <= (best_dist[idx] != DIST_INF);
      rsp.last      <= (cnt == CNT_BITS'(NODES - 1));
    end
  end

endmodule

/* design/dsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_port_checks: port-level checks for dense_shortest_path
// Watches both channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dsp_port_checks
  import dsp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // A run beat blocks further requests while the run is worked on
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.cmd == CMD_RUN && ({1'b0, req.source} < 4'(NODES))
    |=> !req_ready)
    else $error("request taken right after a run beat");

  // A weight write keeps the block open for the next beat
  a_write_open: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.cmd == CMD_WRITE |=> req_ready)
    else $error("request channel closed after a weight write");

  // Last beat belongs to the highest node
  a_last_node: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> rsp.node == 3'(NODES - 1))
    else $error("last flag on wrong node");

  // Reachable flag agrees with the distance code
  a_reach: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.reachable == (rsp.distance != 24'(DIST_INF)))
    else $error("reachable flag disagrees with distance");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

endmodule

bind dense_shortest_path dsp_port_checks u_dsp_port_checks (.*);

/* tb/sv/dsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_checker: shortest path predictor and result checker
// Watches both channels, keeps its own copy of the edge matrix, works out
// each node's distance for every run beat and compares result beats in order.
// ----------------------------------------------------------------------------
module dsp_checker
  import dsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  logic [WEIGHT_BITS-1:0] edge_cost [NODES*NODES];
  logic [DIST_BITS-1:0]   reach_len [NODES];
  logic                   closed    [NODES];
  rsp_t                   route_results_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] dsp mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Edge cost as a distance: no-edge code maps to unreachable
  function automatic logic [DIST_BITS-1:0] link_len(input int a, input int b);
    logic [WEIGHT_BITS-1:0] w;
    w = edge_cost[a*NODES + b];
    if (w == NO_EDGE) return DIST_INF;
    if (64'(w) > 64'(DIST_MAX)) return DIST_MAX;
    return DIST_BITS'(w);
  endfunction

  task automatic solve_routes(input int src);
    int                   pick;
    bit                   found;
    logic [DIST_BITS-1:0] least;
    logic [DIST_BITS-1:0] hop;
    logic [63:0]          sum;
    rsp_t                 r;
    for (int i = 0; i < NODES; i++) begin
      closed[i]    = 1'b0;
      reach_len[i] = link_len(src, i);
    end
    reach_len[src] = '0;
    closed[src]    = 1'b1;
    for (int round = 0; round < NODES - 1; round++) begin
      found = 1'b0;
      pick  = 0;
      least = DIST_INF;
      // lowest index wins ties
      for (int i = 0; i < NODES; i++) begin
        if (!closed[i] && reach_len[i] < least) begin
          least = reach_len[i];
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      closed[pick] = 1'b1;
      for (int j = 0; j < NODES; j++) begin
        hop = link_len(pick, j);
        if (!closed[j] && hop != DIST_INF) begin
          sum = 64'(least) + 64'(hop);
          if (sum > 64'(DIST_MAX)) sum = 64'(DIST_MAX);
          if (sum < 64'(reach_len[j])) reach_len[j] = DIST_BITS'(sum);
        end
      end
    end
    for (int i = 0; i < NODES; i++) begin
      r.node      = i[2:0];
      r.distance  = reach_len[i];
      r.reachable = (reach_len[i] != DIST_INF);
      r.last      = (i == NODES - 1);
      route_results_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (route_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat node %0d", rsp.node));
        end else begin
          want = route_results_q.pop_front();
          if (rsp.node !== want.node)
            report_mismatch($sformatf("node got %0d want %0d", rsp.node, want.node));
          if (rsp.distance !== want.distance)
            report_mismatch($sformatf("node %0d distance got %0d want %0d",
                                      want.node, rsp.distance, want.distance));
          if (rsp.reachable !== want.reachable)
            report_mismatch($sformatf("node %0d reachable got %b want %b",
                                      want.node, rsp.reachable, want.reachable));
          if (rsp.last !== want.last)
            report_mismatch($sformatf("node %0d last got %b want %b",
                                      want.node, rsp.last, want.last));
        end
      end
      if (req_valid && req_ready) begin
        if (req.cmd == CMD_WRITE) begin
          if (int'(req.row) < NODES && int'(req.col) < NODES)
            edge_cost[int'(req.row)*NODES + int'(req.col)] = req.weight[WEIGHT_BITS-1:0];
        end else if (int'(req.source) < NODES) begin
          solve_routes(int'(req.source));
        end
      end
      pending = route_results_q.size();
    end
  end

endmodule

/* tb/sv/tb_dense_shortest_path.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_shortest_path: testbench top for the dense shortest path block
// Fills the edge matrix, runs directed graphs, then random writes and runs
// with random idling on both sides; dsp_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_dense_shortest_path
  import dsp_pkg::*;
();

  // The watchdog limit sits well above the longest quiet stretch that a run
  // inside the block, a receiver stall and a sender gap can make together.
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 212;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int quiet_cycles = 0;

  // Sender / receiver burst modes: when calm, no idle cycles are inserted
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  // Percent of random weights that are the no-edge code; varied by phase
  int sparse_pct = 30;

  always #6 clk = ~clk;

  dense_shortest_path DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  dsp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // --------------------------------------------------------------------------
  // Request side helpers
  // --------------------------------------------------------------------------

  // Present one beat after a random gap and hold it until accepted. With a
  // zero gap the next payload replaces the old one at the accepting edge, so
  // valid never drops between back-to-back beats.
  task automatic push_beat(input req_t b);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && req_ready));
  endtask

  // Fields a command does not use carry random junk; the block must ignore it
  task automatic load_edge(input int r, input int c, input logic [15:0] w);
    req_t b;
    b        = req_t'($urandom);
    b.cmd    = CMD_WRITE;
    b.row    = r[2:0];
    b.col    = c[2:0];
    b.weight = w;
    b.source = 3'($urandom);
    push_beat(b);
  endtask

  task automatic start_run(input int s);
    req_t b;
    b        = req_t'($urandom);
    b.cmd    = CMD_RUN;
    b.row    = 3'($urandom);
    b.col    = 3'($urandom);
    b.weight = 16'($urandom);
    b.source = s[2:0];
    push_beat(b);
  endtask

  // Weight mix: no-edge by phase density, zero, a common small value to
  // force ties, the largest finite code, full-range and small random costs
  function automatic logic [15:0] pick_weight();
    if ($urandom_range(0, 99) < sparse_pct) return NO_EDGE;
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'd5;
      2:       return 16'hFFFE;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, 60));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entry is written before the first run so no run ever reads an
    // undefined weight. Diagonal holds a large cost: the source must still
    // come out at distance zero.
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++)
        load_edge(r, c, (r == c) ? 16'hFFFE : NO_EDGE);

    // Isolated source: search stops at once, all others unreachable
    start_run(3);

    // Small graph with zero-cost edge, largest finite edge, equal-cost
    // branches that tie at node 5, and a zero edge off a far node
    load_edge(0, 1, 16'h0000);
    load_edge(1, 2, 16'hFFFE);
    load_edge(0, 3, 16'd7);
    load_edge(0, 4, 16'd7);
    load_edge(3, 5, 16'd1);
    load_edge(4, 5, 16'd1);
    load_edge(4, 6, 16'd3);
    load_edge(2, 7, 16'hFFFE);
    load_edge(7, 6, 16'h0000);
    start_run(0);

    // Close a cycle back to node 0 with alternating bit patterns
    load_edge(5, 6, 16'h8000);
    load_edge(6, 7, 16'h5555);
    load_edge(7, 0, 16'hAAAA);
    start_run(7);
    start_run(6);
    start_run(5);

    // Remove an edge, then break the tie
    load_edge(0, 1, NO_EDGE);
    start_run(0);
    load_edge(0, 4, 16'h0001);
    start_run(0);
    start_run(1);
    start_run(2);
    start_run(4);

    // Random part: density and sender burst mode change by phase
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) sparse_pct = $urandom_range(5, 85);
      if (n % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        start_run($urandom_range(0, NODES - 1));
      else
        load_edge($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                  pick_weight());
    end
    req_valid <= 1'b0;

    // Drain: wait for every predicted beat, then watch for strays
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS dense_shortest_path");
    end else begin
      $display("FAIL dense_shortest_path");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall before each beat, with calm stretches
  // --------------------------------------------------------------------------
  initial begin : recv
    int stall;
    int beats;
    beats = 0;
    @(negedge rst);
    forever begin
      if (beats % 30 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = recv_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      beats++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL dense_shortest_path");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
